[hw/rtl/fixed_window_rate_limiter_macros.svh]
// assertion macros for the fixed window rate limiter
`ifndef FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FWRL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwrl assertion failed");

// next-cycle implication
`define FWRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwrl assertion failed");

`else

`define FWRL_ASSERT_IMP(label, clk, rst, ante, cons)
`define FWRL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/fwrl_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the fixed window rate limiter
package fwrl_pkg;

   localparam int unsigned RATE_W   = 40;
   localparam int unsigned BYTES_W  = 32;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned STALL_W  = 33;
   localparam int unsigned ELAP_W   = 33;
   localparam int unsigned MUL_A_W  = 64;
   localparam int unsigned MUL_B_W  = 33;
   localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
   localparam int unsigned ALLOW_W  = (RATE_W - 3) + ELAP_W;
   localparam int unsigned NUM_W    = PROD_W;
   localparam int unsigned QUO_W    = 35;
   localparam int unsigned DIV_CNT_W = $clog2(QUO_W);
   localparam int unsigned MUL_PARTS = 4;

   localparam int unsigned CSR_AW = 4;
   localparam int unsigned CSR_DW = 64;
   localparam logic CSR_IDX_RATE = 1'b0;

   localparam logic [STALL_W-1:0] WINDOW_NS = 33'd5000000000;
   localparam logic [29:0]        NS_PER_S  = 30'd1000000000;

   typedef struct packed {
      logic [BYTES_W-1:0] byte_count;
      logic [TIME_W-1:0]  now_ns;
   } fwrl_req_word_type;

   typedef struct packed {
      logic [STALL_W-1:0] stall_ns;
      logic               throttled;
   } fwrl_rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fwrl_mul_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic ovf;
   } fwrl_div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ELAP,
      ST_MUL_ALLOW,
      ST_MUL_LOAD,
      ST_CMP,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } fwrl_state_type;

endpackage

[hw/rtl/fwrl_mul.sv]
`timescale 1ns / 1ps
// 64 x 33 multiplier built from four passes through one 32 x 32 multiplier
module fwrl_mul
   import fwrl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MUL_A_W-1:0]     a,
   input  logic [MUL_B_W-1:0]     b,
   output fwrl_mul_stat_type      stat,
   output logic [PROD_W-1:0]      prod
);

   localparam int unsigned CNT_W = $clog2(MUL_PARTS + 1);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [63:0]        pp_ff, pp_in;
   logic               pp_vld_ff, pp_vld_in;
   logic [1:0]         sh_ff, sh_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [31:0]        x_op;
   logic [31:0]        y_op;
   logic [PROD_W-1:0]  addend;

   assign x_op = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign y_op = cnt_ff[1] ? {31'b0, b_ff[32]} : b_ff[31:0];

   // partial product weights 2^0, 2^32, 2^64
   always_comb begin
      case (sh_ff)
         2'd0:    addend = {33'b0, pp_ff};
         2'd1:    addend = {1'b0, pp_ff, 32'b0};
         2'd2:    addend = {pp_ff[32:0], 64'b0};
         default: addend = '0;
      endcase
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      pp_in     = pp_ff;
      pp_vld_in = 1'b0;
      sh_in     = sh_ff;
      acc_in    = acc_ff;
      if (pp_vld_ff) begin
         acc_in = acc_ff + addend;
      end
      if (start) begin
         a_in   = a;
         b_in   = b;
         cnt_in = '0;
         run_in = 1'b1;
         acc_in = '0;
      end else if (run_ff) begin
         if (cnt_ff == CNT_W'(MUL_PARTS)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            pp_in     = x_op * y_op;
            pp_vld_in = 1'b1;
            sh_in     = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
            cnt_in    = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         done_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         run_ff    <= run_in;
         done_ff   <= done_in;
         pp_vld_ff <= pp_vld_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = run_ff | pp_vld_ff;
   assign stat.done = done_ff;
   assign prod      = acc_ff;

endmodule

[hw/rtl/fwrl_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, with early overflow detect
module fwrl_div
   import fwrl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    num,
   input  logic [RATE_W-1:0]   den,
   output fwrl_div_stat_type   stat,
   output logic [QUO_W-1:0]    quo
);

   localparam int unsigned HI_W = NUM_W - QUO_W;

   logic [RATE_W-1:0]    den_ff, den_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]     sh_ff, sh_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 ovf_ff, ovf_in;
   logic [RATE_W:0]      trial;
   logic [RATE_W:0]      trial_sub;
   logic                 trial_ge;
   logic [HI_W-1:0]      num_hi;
   logic                 hi_ovf;

   assign trial     = {rem_ff, sh_ff[QUO_W-1]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   // quotient needs more than QUO_W bits when the top part already reaches den
   assign num_hi = num[NUM_W-1:QUO_W];
   assign hi_ovf = num_hi >= HI_W'(den);

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      if (start) begin
         den_in  = den;
         ovf_in  = hi_ovf;
         rem_in  = num_hi[RATE_W-1:0];
         sh_in   = num[QUO_W-1:0];
         cnt_in  = '0;
         run_in  = ~hi_ovf;
         done_in = hi_ovf;
      end else if (run_ff) begin
         rem_in = trial_ge ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
         sh_in  = {sh_ff[QUO_W-2:0], trial_ge};
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign quo       = sh_ff;

endmodule

[hw/rtl/fwrl_core.sv]
`timescale 1ns / 1ps
// window state, sequencer and result register of the rate limiter
`include "fixed_window_rate_limiter_macros.svh"
module fwrl_core
   import fwrl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [RATE_W-1:0]  rate,
   input  logic               req_valid,
   output logic               req_stall,
   input  fwrl_req_word_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fwrl_rsp_word_type  rsp_data
);

   fwrl_state_type     state_ff, state_in;
   logic [TIME_W-1:0]  ws_ff, ws_in;
   logic [TIME_W-1:0]  wb_ff, wb_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [ELAP_W-1:0]  el_ff, el_in;
   logic [ALLOW_W-1:0] p1_ff, p1_in;
   logic [STALL_W-1:0] res_stall_ff, res_stall_in;
   logic               res_thr_ff, res_thr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fwrl_rsp_word_type  rsp_data_ff, rsp_data_in;
   logic               rsp_load;

   logic [TIME_W-1:0]  wb_base;
   logic [TIME_W:0]    wb_sum;
   logic [TIME_W-1:0]  elapsed;
   logic [QUO_W-1:0]   q_diff;
   logic               q_gt;

   logic               mul_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   fwrl_mul_stat_type  mul_st;
   logic [PROD_W-1:0]  mul_prod;
   logic               div_start;
   fwrl_div_stat_type  div_st;
   logic [QUO_W-1:0]   div_quo;

   fwrl_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .stat  (mul_st),
      .prod  (mul_prod)
   );

   // numerator is bytes * 8e9, i.e. the bytes * 1e9 product shifted by three
   fwrl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({mul_prod[NUM_W-4:0], 3'b000}),
      .den   (rate),
      .stat  (div_st),
      .quo   (div_quo)
   );

   // no window yet means the total starts from zero
   assign wb_base = (ws_ff == '0) ? '0 : wb_ff;
   assign wb_sum  = {1'b0, wb_base} + {{(TIME_W - BYTES_W + 1){1'b0}}, bytes_ff};
   assign elapsed = now_ff - ws_ff;
   assign q_gt    = div_quo > {{(QUO_W - ELAP_W){1'b0}}, el_ff};
   assign q_diff  = div_quo - {{(QUO_W - ELAP_W){1'b0}}, el_ff};

   always_comb begin
      state_in     = state_ff;
      ws_in        = ws_ff;
      wb_in        = wb_ff;
      bytes_in     = bytes_ff;
      now_in       = now_ff;
      el_in        = el_ff;
      p1_in        = p1_ff;
      res_stall_in = res_stall_ff;
      res_thr_in   = res_thr_ff;
      mul_start    = 1'b0;
      mul_a        = wb_ff;
      mul_b        = {{(MUL_B_W - 30){1'b0}}, NS_PER_S};
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bytes_in     = req_data.byte_count;
               now_in       = req_data.now_ns;
               res_stall_in = '0;
               res_thr_in   = 1'b0;
               state_in     = (rate == '0) ? ST_DONE : ST_PREP;
            end
         end
         ST_PREP: begin
            if (ws_ff == '0) begin
               ws_in = now_ff;
            end
            wb_in    = wb_sum[TIME_W] ? '1 : wb_sum[TIME_W-1:0];
            state_in = ST_ELAP;
         end
         ST_ELAP: begin
            if (elapsed > TIME_W'(WINDOW_NS)) begin
               // stale window or time went backwards
               ws_in    = now_ff;
               wb_in    = {{(TIME_W - BYTES_W){1'b0}}, bytes_ff};
               state_in = ST_DONE;
            end else begin
               el_in     = elapsed[ELAP_W-1:0];
               mul_start = 1'b1;
               mul_a     = {{(MUL_A_W - RATE_W + 3){1'b0}}, rate[RATE_W-1:3]};
               mul_b     = elapsed[ELAP_W-1:0];
               state_in  = ST_MUL_ALLOW;
            end
         end
         ST_MUL_ALLOW: begin
            if (mul_st.done) begin
               p1_in     = mul_prod[ALLOW_W-1:0];
               mul_start = 1'b1;
               state_in  = ST_MUL_LOAD;
            end
         end
         ST_MUL_LOAD: begin
            if (mul_st.done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            // bytes > floor(p1 / 1e9) is the same as bytes * 1e9 > p1
            if (mul_prod > {{(PROD_W - ALLOW_W){1'b0}}, p1_ff}) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!div_st.ovf && q_gt && (q_diff < QUO_W'(WINDOW_NS))) begin
               res_stall_in = q_diff[STALL_W-1:0];
               res_thr_in   = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.stall_ns  = res_stall_ff;
         rsp_data_in.throttled = res_thr_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= '0;
         wb_ff        <= '0;
         res_thr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         wb_ff        <= wb_in;
         res_thr_ff   <= res_thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff     <= bytes_in;
      now_ff       <= now_in;
      el_ff        <= el_in;
      p1_ff        <= p1_in;
      res_stall_ff <= res_stall_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FWRL_ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE)
   `FWRL_ASSERT_NEXT(a_rate_off_skips, clock, reset, req_valid && !req_stall && (rate == '0), state_ff == ST_DONE)
   `FWRL_ASSERT_IMP(a_units_exclusive, clock, reset, mul_st.busy, !div_st.busy)
   `FWRL_ASSERT_IMP(a_throttle_nonzero, clock, reset, res_thr_ff, res_stall_ff != '0)

endmodule

[hw/rtl/fixed_window_rate_limiter.sv]
`timescale 1ns / 1ps
// top level of the fixed window rate limiter: register port and core
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  byte_count, now_ns
//   rsp_     out        rsp_valid/rsp_stall  stall_ns, throttled
//   csr      in/out     psel/penable/pready  target_rate_bps at address 0
//
// one word in flight at a time; req_stall is high from acceptance until the result
// is placed in the output register. When the stall quotient runs, a word takes two
// four-pass products on the 32x32 multiplier, then 35 divider steps; a total that
// fits the window skips the divider, a window restart skips both units and a zero
// rate also leaves the window untouched. A stalled output delays the next word.
// reset is synchronous: rate zero, no window, empty output register.
// a stalled result holds the core in its last state until taken.
module fixed_window_rate_limiter
   import fwrl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fwrl_req_word_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fwrl_rsp_word_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              csr_wr;
   logic              csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   // registers sit on 8-byte boundaries
   assign csr_idx = paddr[3];

   always_comb begin
      rate_in = rate_ff;
      if (csr_wr && (csr_idx == CSR_IDX_RATE)) begin
         rate_in = pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= '0;
      end else begin
         rate_ff <= rate_in;
      end
   end

   assign prdata = (csr_idx == CSR_IDX_RATE) ? {{(CSR_DW - RATE_W){1'b0}}, rate_ff} : '0;

   fwrl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .rate      (rate_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
